// ===== rtl/afe_pkg.sv =====
// shared types, constants and the sine table of the fade envelope
`default_nettype none

package afe_pkg;

    localparam int TIME_BITS      = 24;
    localparam int LEN_BITS       = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int T_BITS         = 17;
    localparam int SINE_ENTRIES   = 256;
    localparam int SINE_IDX_BITS  = 8;
    localparam int SINE_ADDR_BITS = SINE_IDX_BITS + 1;
    localparam int DIV_STEPS      = 16;
    localparam int DIV_CNT_BITS   = 4;
    localparam int MUL_A_BITS     = 17;
    localparam int MUL_B_BITS     = 18;
    localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
    localparam int IN_DATA_BITS   = 2 * TIME_BITS + GAIN_BITS;

    localparam logic [T_BITS-1:0]     ONE_Q16     = T_BITS'(65536);
    localparam logic [GAIN_BITS-1:0]  UNITY_GAIN  = GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic [MUL_B_BITS-1:0] SMOOTH_C3   = MUL_B_BITS'(3 * 65536);
    localparam logic [PROD_BITS-1:0]  ROUND_HALF  = PROD_BITS'(32768);
    localparam logic [LEN_BITS-1:0]   LEN_RESET   = LEN_BITS'(1000);
    localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic REG_FADE_IN  = 1'b0;
    localparam logic REG_FADE_OUT = 1'b1;

    typedef enum logic [1:0] {
        MUL_SINE,
        MUL_SQ,
        MUL_SMOOTH,
        MUL_LERP
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     calc_start;
        logic     calc_num;
        logic     div_init;
        logic     div_step;
        logic     lookup;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic restart;
        logic running;
        logic fading_in;
        logic before_window;
        logic num_ge_den;
        logic out_free;
    } t_dp_sts;

    typedef logic [T_BITS-1:0] t_sine_tab [0:SINE_ENTRIES];

    // quarter sine in q1.16, taylor series in q2.30, evaluated at elaboration
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int unsigned i;
        int unsigned k;
        for (i = 0; i <= SINE_ENTRIES; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (k = 1; k <= 8; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) != 0) begin
                    sum = (sum > term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            sum = (sum + 64'd8192) >> 14;
            tab[i] = (sum > 64'(ONE_Q16)) ? ONE_Q16 : sum[T_BITS-1:0];
        end
        tab[0]            = '0;
        tab[SINE_ENTRIES] = ONE_Q16;
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== rtl/afe_ctrl.sv =====
// sequencer of the fade envelope: steps the datapath through one word
`default_nettype none

module afe_ctrl
    import afe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_START  = 11'b000_0000_0010,
        S_TEST   = 11'b000_0000_0100,
        S_CMP    = 11'b000_0000_1000,
        S_DIV    = 11'b000_0001_0000,
        S_LOOKUP = 11'b000_0010_0000,
        S_SINE   = 11'b000_0100_0000,
        S_SQ     = 11'b000_1000_0000,
        S_SMOOTH = 11'b001_0000_0000,
        S_LERP   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [DIV_CNT_BITS-1:0] r_div_cnt;
    logic [DIV_CNT_BITS-1:0] n_div_cnt;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.calc_start = 1'b1;
                if (i_sts.restart) begin
                    n_state = S_OUT;
                end else if (!i_sts.running) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.calc_num = 1'b1;
                if (!i_sts.fading_in && i_sts.before_window) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.div_init = 1'b1;
                n_div_cnt      = '0;
                if (!i_sts.num_ge_den) begin
                    n_state = S_DIV;
                end else if (i_sts.fading_in) begin
                    n_state = S_LOOKUP;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIV_CNT_BITS'(1);
                if (r_div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = i_sts.fading_in ? S_LOOKUP : S_SQ;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_SINE;
            end
            S_SINE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SINE;
                n_state       = S_LERP;
            end
            S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
                n_state       = S_SMOOTH;
            end
            S_SMOOTH: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SMOOTH;
                n_state       = S_LERP;
            end
            S_LERP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LERP;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    // a word is only taken when nothing is in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_s_tready)
        else $error("afe_ctrl: ready while a word is in flight");

    // once entered, the divider always runs its full count before the curve stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_div_cnt != DIV_CNT_BITS'(DIV_STEPS - 1))
        |=> (r_state == S_DIV))
        else $error("afe_ctrl: divider left early");

    // a result is only loaded when the output register can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("afe_ctrl: output overwritten");

endmodule

`default_nettype wire

// ===== rtl/afe_datapath.sv =====
// datapath of the fade envelope: divider, sine lookup, shared multiplier, state
`default_nettype none

module afe_datapath
    import afe_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_sts                      o_sts,
    input  wire logic [IN_DATA_BITS-1:0] i_s_tdata,
    input  wire logic                    i_s_tuser,
    input  wire logic [LEN_BITS-1:0]     i_fade_in_len,
    input  wire logic [LEN_BITS-1:0]     i_fade_out_len,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [GAIN_BITS-1:0]         o_m_tdata,
    output logic                         o_m_tuser,
    output logic                         o_m_tlast
);

    // input word
    logic                  r_restart;
    logic [TIME_BITS-1:0]  r_pos;
    logic [TIME_BITS-1:0]  r_len;
    logic [GAIN_BITS-1:0]  r_target;
    // work registers
    logic [TIME_BITS-1:0]  r_start;
    logic [TIME_BITS-1:0]  r_num;
    logic [LEN_BITS-1:0]   r_rem;
    logic [T_BITS-1:0]     r_t;
    logic [T_BITS-1:0]     r_a;
    logic [T_BITS-1:0]     r_d;
    logic [T_BITS-1:0]     r_s;
    logic [GAIN_BITS-1:0]  r_diff;
    logic                  r_up;
    logic [GAIN_BITS-1:0]  r_gain;
    // envelope state
    logic                  r_running;
    logic                  r_fading_in;
    logic [GAIN_BITS-1:0]  r_start_level;
    // output register
    logic                  r_m_valid;
    logic [GAIN_BITS-1:0]  r_m_gain;
    logic                  r_m_fade;
    logic                  r_m_last;

    logic [LEN_BITS-1:0]       fin_eff;
    logic [LEN_BITS-1:0]       fout_eff;
    logic [LEN_BITS-1:0]       den;
    logic [GAIN_BITS-1:0]      target_in;
    logic [GAIN_BITS-1:0]      lerp_end;
    logic [LEN_BITS:0]         div_tmp;
    logic                      div_ge;
    logic [SINE_ADDR_BITS-1:0] a_idx;
    logic [SINE_ADDR_BITS-1:0] b_idx;
    logic [T_BITS-1:0]         tab_a;
    logic [T_BITS-1:0]         tab_b;
    logic [MUL_A_BITS-1:0]     mul_a;
    logic [MUL_B_BITS-1:0]     mul_b;
    logic [PROD_BITS-1:0]      prod;
    logic [PROD_BITS-1:0]      prod_rnd;
    logic [PROD_BITS-17:0]     rnd;
    logic                      full;

    assign fin_eff  = (i_fade_in_len == '0) ? LEN_BITS'(1) : i_fade_in_len;
    assign fout_eff = (i_fade_out_len == '0) ? LEN_BITS'(1) : i_fade_out_len;
    assign den      = r_fading_in ? fin_eff : fout_eff;

    assign target_in = (i_s_tdata[IN_DATA_BITS-1 -: GAIN_BITS] > UNITY_GAIN) ?
                       UNITY_GAIN : i_s_tdata[IN_DATA_BITS-1 -: GAIN_BITS];
    assign lerp_end  = r_fading_in ? r_target : '0;

    // restoring divider, one quotient bit per step; remainder stays below den
    assign div_tmp = {r_rem, 1'b0};
    assign div_ge  = (div_tmp >= {1'b0, den});

    assign a_idx = {1'b0, r_t[15 -: SINE_IDX_BITS]};
    assign b_idx = a_idx + SINE_ADDR_BITS'(1);
    assign tab_a = SINE_TAB[a_idx];
    assign tab_b = SINE_TAB[b_idx];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SINE: begin
                mul_a = r_d;
                mul_b = {2'b00, r_t[7:0], 8'h00};
            end
            MUL_SQ: begin
                mul_a = r_t;
                mul_b = {1'b0, r_t};
            end
            MUL_SMOOTH: begin
                mul_a = r_a;
                mul_b = SMOOTH_C3 - {r_t, 1'b0};
            end
            MUL_LERP: begin
                mul_a = {1'b0, r_diff};
                mul_b = {1'b0, r_s};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign prod_rnd = prod + ROUND_HALF;
    assign rnd      = prod_rnd[PROD_BITS-1:16];
    assign full     = r_s[T_BITS-1];

    assign o_sts.restart       = r_restart;
    assign o_sts.running       = r_running;
    assign o_sts.fading_in     = r_fading_in;
    assign o_sts.before_window = (r_pos < r_start);
    assign o_sts.num_ge_den    = (r_num >= TIME_BITS'(den));
    assign o_sts.out_free      = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_restart <= i_s_tuser;
            r_pos     <= i_s_tdata[TIME_BITS-1:0];
            r_len     <= i_s_tdata[2*TIME_BITS-1:TIME_BITS];
            r_target  <= target_in;
        end
        if (i_cmd.calc_start) begin
            r_start <= (r_len > TIME_BITS'(fout_eff)) ? r_len - TIME_BITS'(fout_eff) : '0;
        end
        if (i_cmd.calc_num) begin
            r_num  <= r_fading_in ? r_pos : r_pos - r_start;
            r_up   <= (lerp_end >= r_start_level);
            r_diff <= (lerp_end >= r_start_level) ? lerp_end - r_start_level
                                                  : r_start_level - lerp_end;
        end
        if (i_cmd.div_init) begin
            r_rem <= r_num[LEN_BITS-1:0];
            r_t   <= o_sts.num_ge_den ? ONE_Q16 : '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? LEN_BITS'(div_tmp - {1'b0, den}) : div_tmp[LEN_BITS-1:0];
            r_t   <= {r_t[T_BITS-2:0], div_ge};
        end
        if (i_cmd.lookup) begin
            // at t = 1 the curve sits on the last entry with no slope
            if (r_t[T_BITS-1]) begin
                r_a <= SINE_TAB[SINE_ENTRIES];
                r_d <= '0;
            end else begin
                r_a <= tab_a;
                r_d <= (tab_b > tab_a) ? tab_b - tab_a : '0;
            end
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_SINE: begin
                    r_s <= r_a + rnd[T_BITS-1:0];
                end
                MUL_SQ: begin
                    r_a <= rnd[T_BITS-1:0];
                end
                MUL_SMOOTH: begin
                    r_s <= (rnd > (PROD_BITS-16)'(ONE_Q16)) ? ONE_Q16 : rnd[T_BITS-1:0];
                end
                MUL_LERP: begin
                    r_gain <= r_up ? r_start_level + rnd[GAIN_BITS-1:0]
                                   : r_start_level - rnd[GAIN_BITS-1:0];
                end
                default: begin
                    r_gain <= r_gain;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b1;
            r_fading_in   <= 1'b1;
            r_start_level <= '0;
        end else if (i_cmd.out_load) begin
            if (r_restart) begin
                r_running     <= 1'b1;
                r_fading_in   <= 1'b1;
                r_start_level <= '0;
            end else if (r_fading_in) begin
                if (full) begin
                    r_fading_in   <= 1'b0;
                    r_start_level <= r_target;
                end
            end else if (full) begin
                r_running <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_restart) begin
                r_m_gain <= '0;
                r_m_fade <= 1'b1;
                r_m_last <= 1'b0;
            end else if (r_fading_in) begin
                r_m_gain <= full ? r_target : r_gain;
                r_m_fade <= !full;
                r_m_last <= 1'b0;
            end else begin
                r_m_gain <= full ? '0 : r_gain;
                r_m_fade <= 1'b0;
                r_m_last <= full;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_gain;
    assign o_m_tuser  = r_m_fade;
    assign o_m_tlast  = r_m_last;

    // the fade-in phase only exists while the envelope is active
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fading_in |-> r_running)
        else $error("afe_datapath: fading in while inactive");

    // a finished word closes the fade-out at silence
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tdata == '0) && !o_m_tuser)
        else $error("afe_datapath: finish word not silent");

    // gain never exceeds unity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata <= UNITY_GAIN))
        else $error("afe_datapath: gain above unity");

    // a finish word leaves the envelope inactive
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && !r_restart && !r_fading_in && full |=> !r_running)
        else $error("afe_datapath: still active after fade-out");

endmodule

`default_nettype wire

// ===== rtl/audio_fade_envelope.sv =====
// top level of the fade envelope: register port, sequencer and datapath
`default_nettype none

// Gain envelope for one audio source. Each input word is either a tick
// (play position, track length, target gain) or a restart, and gives at most
// one output word with the gain to apply in Q1.15. While fading in, the gain
// follows an ease-out sine from the start level to the target; after the
// fade-in it holds, and from track_length - fade_out_length on it falls to
// zero along a smoothstep, then the block goes quiet until a restart. Ticks
// that change nothing (inactive, or before the fade-out window) give no word.
// A word keeps the block busy until it is done. An inactive tick ends at the
// start step, a restart goes on to output, a tick before the fade-out window
// ends at the test step, and other ticks run the divider (skipped when the
// ratio saturates), the curve and output. The position-over-length ratio
// comes from a restoring divider that yields one quotient bit per cycle, and
// one shared 17x18 multiplier makes two passes per fade-in word and three
// per fade-out word. The output register decouples the sides, but a result
// not yet taken holds the next one back. Fade lengths must be written over
// the register port only while idle; the block itself does not enforce this.

module audio_fade_envelope
    import afe_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // register port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input words
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // play_position [23:0], track_length [47:24], target_gain [63:48]
    input  wire logic [IN_DATA_BITS-1:0] s_axis_tdata,
    // command [0]: 0 tick, 1 restart
    input  wire logic                    s_axis_tuser,
    // output words
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // gain [15:0]
    output logic [GAIN_BITS-1:0]         m_axis_tdata,
    // in_fade_in [0]
    output logic                         m_axis_tuser,
    // finished
    output logic                         m_axis_tlast
);

    logic [LEN_BITS-1:0] r_fade_in_len;
    logic [LEN_BITS-1:0] r_fade_out_len;
    logic                reg_wr;
    t_dp_cmd             dp_cmd;
    t_dp_sts             dp_sts;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in_len  <= LEN_RESET;
            r_fade_out_len <= LEN_RESET;
        end else if (reg_wr) begin
            unique case (paddr[2])
                REG_FADE_IN:  r_fade_in_len  <= pwdata[LEN_BITS-1:0];
                REG_FADE_OUT: r_fade_out_len <= pwdata[LEN_BITS-1:0];
                default:      r_fade_in_len  <= r_fade_in_len;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FADE_IN:  prdata = {16'h0000, r_fade_in_len};
            REG_FADE_OUT: prdata = {16'h0000, r_fade_out_len};
            default:      prdata = '0;
        endcase
    end

    afe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    afe_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_fade_in_len  (r_fade_in_len),
        .i_fade_out_len (r_fade_out_len),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata),
        .o_m_tuser      (m_axis_tuser),
        .o_m_tlast      (m_axis_tlast)
    );

    // configuration changes must only come while no word is in flight; the block does not enforce this
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reg_wr |-> s_axis_tready)
        else $error("audio_fade_envelope: register write while busy");

endmodule

`default_nettype wire
